@@ rtl/core/dtps_pkg.sv @@
package dtps_pkg;

	// Field widths of the pixel command and result words.
	localparam int FUNC_W     = 3;
	localparam int POS_W      = 8;
	localparam int DIM_W      = 9;
	localparam int DEPTH_IN_W = 32;
	localparam int CHAN_IN_W  = 16;
	localparam int CHAN_W     = 8;
	localparam int STATUS_W   = 2;
	localparam int RGB_W      = 3 * CHAN_W;

	// Store geometry and number formats.
	localparam int MAX_WIDTH       = 256;
	localparam int MAX_HEIGHT      = 256;
	localparam int STORE_SIZE      = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W          = $clog2(STORE_SIZE);
	localparam int DEPTH_BITS      = 32;
	localparam int COLOR_FRAC_BITS = 12;

	// Command codes.
	localparam logic [FUNC_W-1:0] FUNC_WRITE     = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_TEST      = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ      = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_CLR_COLOR = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_CLR_DEPTH = 3'd4;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

	// Configuration register indexes.
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Decoded command as it travels down the pipeline.
	typedef struct packed {
		logic                  is_write;
		logic                  is_test;
		logic                  is_read;
		logic                  clr_color;
		logic                  clr_depth;
		logic                  oor;
		logic [ADDR_W-1:0]     addr;
		logic [DEPTH_BITS-1:0] depth;
		logic [RGB_W-1:0]      color;
	} pix_t;

	// Request to start a clearing pass over one or both stores.
	typedef struct packed {
		logic color;
		logic depth;
	} clr_req_t;

	// Write port control from the clear sequencer.
	typedef struct packed {
		logic              busy;
		logic              wr_color;
		logic              wr_depth;
		logic [ADDR_W-1:0] addr;
	} sweep_t;

	typedef enum logic {
		SWP_IDLE,
		SWP_RUN
	} sweep_state_t;

endpackage

@@ rtl/core/dtps_ram.sv @@
module dtps_ram #(
	parameter int DATA_W = 32,
	parameter int ADDR_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem [DEPTH];

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

@@ rtl/core/dtps_front.sv @@
module dtps_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load,
	input  logic                                 drain,
	input  logic [dtps_pkg::FUNC_W-1:0]          func,
	input  logic [dtps_pkg::POS_W-1:0]           pos_x,
	input  logic [dtps_pkg::POS_W-1:0]           pos_y,
	input  logic signed [dtps_pkg::DEPTH_IN_W-1:0] depth_in,
	input  logic signed [dtps_pkg::CHAN_IN_W-1:0]  red_in,
	input  logic signed [dtps_pkg::CHAN_IN_W-1:0]  green_in,
	input  logic signed [dtps_pkg::CHAN_IN_W-1:0]  blue_in,
	input  logic [dtps_pkg::DIM_W-1:0]           frame_width,
	input  logic [dtps_pkg::DIM_W-1:0]           frame_height,
	output logic                                 vld_s1,
	output dtps_pkg::pix_t                       pix_s1
);

	import dtps_pkg::*;

	localparam int PROD_W = COLOR_FRAC_BITS + CHAN_W;
	localparam int SUM_W  = POS_W + DIM_W;

	// Clamp a signed fixed-point channel to 0..1 and scale it to a byte.
	function automatic logic [CHAN_W-1:0] chan_to_byte(input logic [CHAN_IN_W-1:0] v);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(v[COLOR_FRAC_BITS-1:0]) * PROD_W'(255);
		if (v[CHAN_IN_W-1]) begin
			return '0;
		end else if (v[CHAN_IN_W-2:0] >= (CHAN_IN_W-1)'(1 << COLOR_FRAC_BITS)) begin
			return '1;
		end else begin
			return prod[PROD_W-1:COLOR_FRAC_BITS];
		end
	endfunction

	logic             is_pix;
	logic             in_range;
	logic [SUM_W-1:0] addr_full;
	pix_t             pix_d;

	always_comb begin
		is_pix    = (func == FUNC_WRITE) || (func == FUNC_TEST) || (func == FUNC_READ);
		in_range  = (DIM_W'(pos_x) < frame_width) && (DIM_W'(pos_y) < frame_height);
		addr_full = SUM_W'(pos_y) * SUM_W'(frame_width) + SUM_W'(pos_x);

		pix_d.is_write  = (func == FUNC_WRITE);
		pix_d.is_test   = (func == FUNC_TEST);
		pix_d.is_read   = (func == FUNC_READ);
		pix_d.clr_color = (func == FUNC_CLR_COLOR);
		pix_d.clr_depth = (func == FUNC_CLR_DEPTH);
		pix_d.oor       = is_pix && !in_range;
		pix_d.addr      = addr_full[ADDR_W-1:0];
		pix_d.depth     = depth_in[DEPTH_BITS-1:0];
		pix_d.color     = {chan_to_byte(red_in), chan_to_byte(green_in),
			chan_to_byte(blue_in)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (load) begin
			vld_s1 <= 1'b1;
		end else if (drain) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pix_s1 <= pix_d;
		end
	end

endmodule

@@ rtl/core/dtps_sweep.sv @@
module dtps_sweep (
	input  logic               clk,
	input  logic               arst_n,
	input  dtps_pkg::clr_req_t req,
	output dtps_pkg::sweep_t   sw
);

	import dtps_pkg::*;

	sweep_state_t      state_q;
	sweep_state_t      state_d;
	logic [ADDR_W-1:0] cnt_q;
	logic              clr_color_q;
	logic              clr_depth_q;
	logic              start;
	logic              last;

	assign start = req.color || req.depth;
	assign last  = (cnt_q == ADDR_W'(STORE_SIZE - 1));

	// Next state.
	always_comb begin
		unique case (state_q)
			SWP_IDLE: begin
				state_d = start ? SWP_RUN : SWP_IDLE;
			end
			SWP_RUN: begin
				state_d = (!start && last) ? SWP_IDLE : SWP_RUN;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		sw.busy     = (state_q == SWP_RUN);
		sw.wr_color = (state_q == SWP_RUN) && clr_color_q;
		sw.wr_depth = (state_q == SWP_RUN) && clr_depth_q;
		sw.addr     = cnt_q;
	end

	// Reset starts a pass over both stores. A new request restarts the walk
	// from entry zero and keeps any store that was already being cleared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SWP_RUN;
			cnt_q       <= '0;
			clr_color_q <= 1'b1;
			clr_depth_q <= 1'b1;
		end else begin
			state_q <= state_d;
			if (start) begin
				cnt_q       <= '0;
				clr_color_q <= req.color || (sw.busy && clr_color_q);
				clr_depth_q <= req.depth || (sw.busy && clr_depth_q);
			end else if (sw.busy) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/depth_tested_pixel_store_core.sv @@
// Channel   Handshake                      Payload
// input     s_axis_tvalid / s_axis_tready  tuser: func; tdata: pos_x .. blue_in
// result    m_axis_tvalid / m_axis_tready  tuser: status; tdata: red, green, blue
// config    cfg_valid / cfg_ready          cfg_index, cfg_data
//
// A word is accepted every cycle while no clearing pass runs or waits in the
// pipeline and the result side keeps up. The accepting edge loads the front stage;
// the word then moves on to the memory read stage and the output register.
// Reset starts a clearing pass over both stores, one entry per cycle on the memory
// write port; input is held off until it ends. A clear command starts such a pass
// over the store it names, and any configuration write starts one over both stores.
// A stall on the result side backs up through the pipeline to s_axis_tready.
module depth_tested_pixel_store_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// bits from low: pos_x[7:0], pos_y[15:8], depth_in[47:16], red_in[63:48],
	// green_in[79:64], blue_in[95:80]
	input  logic [95:0]                      s_axis_tdata,
	// bits from low: func[2:0]
	input  logic [dtps_pkg::FUNC_W-1:0]      s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// bits from low: red_out[7:0], green_out[15:8], blue_out[23:16]
	output logic [dtps_pkg::RGB_W-1:0]       m_axis_tdata,
	// bits from low: status[1:0]
	output logic [dtps_pkg::STATUS_W-1:0]    m_axis_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_index,
	input  logic [dtps_pkg::DIM_W-1:0]       cfg_data
);

	import dtps_pkg::*;

	// Clamp a written dimension: zero acts as one, and anything above the
	// store's maximum acts as that maximum.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] maxv);
		if (v == '0) begin
			return DIM_W'(1);
		end else if (v > maxv) begin
			return maxv;
		end else begin
			return v;
		end
	endfunction

	// Configuration registers.
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic             cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(MAX_WIDTH);
			height_q <= DIM_W'(MAX_HEIGHT);
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= clamp_dim(cfg_data, DIM_W'(MAX_WIDTH));
				REG_HEIGHT: height_q <= clamp_dim(cfg_data, DIM_W'(MAX_HEIGHT));
			endcase
		end
	end

	// Pipeline flow control. The front stage and output register take a new word when
	// empty or when their word leaves in the same cycle; stage two loads with the output.
	logic   vld_s1;
	logic   vld_s2;
	logic   out_vld_q;
	logic   s2_open;
	logic   s1_open;
	logic   in_accept;
	logic   clr_pending;
	pix_t   pix_s1;
	pix_t   pix_s2;
	sweep_t sw;

	assign s2_open   = !out_vld_q || m_axis_tready;
	assign s1_open   = !vld_s1 || s2_open;

	// Nothing may follow a clear into the pipeline: the pass it starts must
	// not overlap a read or a write of a later word.
	assign clr_pending = (vld_s1 && (pix_s1.clr_color || pix_s1.clr_depth)) ||
		(vld_s2 && (pix_s2.clr_color || pix_s2.clr_depth));

	assign s_axis_tready = s1_open && !sw.busy && !clr_pending;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	// Front stage: command decode, range check, address and colour conversion.
	dtps_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (in_accept),
		.drain        (s2_open),
		.func         (s_axis_tuser),
		.pos_x        (s_axis_tdata[7:0]),
		.pos_y        (s_axis_tdata[15:8]),
		.depth_in     (s_axis_tdata[47:16]),
		.red_in       (s_axis_tdata[63:48]),
		.green_in     (s_axis_tdata[79:64]),
		.blue_in      (s_axis_tdata[95:80]),
		.frame_width  (width_q),
		.frame_height (height_q),
		.vld_s1       (vld_s1),
		.pix_s1       (pix_s1)
	);

	// Second stage holds the word while the stores answer its read.
	logic rd_en;

	assign rd_en = vld_s1 && s2_open;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s2_open) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			pix_s2 <= pix_s1;
		end
	end

	// Stores. The read is issued as a word enters the second stage; the
	// write-back happens as it leaves.
	logic [RGB_W-1:0]      color_rd;
	logic [DEPTH_BITS-1:0] depth_rd;
	logic                  color_we;
	logic                  depth_we;
	logic [ADDR_W-1:0]     wr_addr;
	logic [RGB_W-1:0]      color_wd;
	logic [DEPTH_BITS-1:0] depth_wd;
	logic                  s2_move;
	logic                  s2_color_wr;
	logic                  s2_depth_wr;

	assign s2_move  = vld_s2 && s2_open;
	assign color_we = sw.wr_color || (s2_move && s2_color_wr);
	assign depth_we = sw.wr_depth || (s2_move && s2_depth_wr);
	assign wr_addr  = sw.busy ? sw.addr : pix_s2.addr;
	assign color_wd = sw.busy ? '0 : pix_s2.color;
	assign depth_wd = sw.busy ? '0 : pix_s2.depth;

	dtps_ram #(
		.DATA_W (RGB_W),
		.ADDR_W (ADDR_W)
	) u_color_ram (
		.clk   (clk),
		.we    (color_we),
		.waddr (wr_addr),
		.wdata (color_wd),
		.re    (rd_en),
		.raddr (pix_s1.addr),
		.rdata (color_rd)
	);

	dtps_ram #(
		.DATA_W (DEPTH_BITS),
		.ADDR_W (ADDR_W)
	) u_depth_ram (
		.clk   (clk),
		.we    (depth_we),
		.waddr (wr_addr),
		.wdata (depth_wd),
		.re    (rd_en),
		.raddr (pix_s1.addr),
		.rdata (depth_rd)
	);

	// Forwarding. The word just ahead writes on the same edge that this word
	// reads, so the memory returns the old entry; the last write is kept here
	// and overrides the read data when the address matches. Older writes have
	// already reached the memory. A clearing pass drops the held write.
	logic                  fwd_color_vld_q;
	logic                  fwd_depth_vld_q;
	logic [ADDR_W-1:0]     fwd_addr_q;
	logic [RGB_W-1:0]      fwd_color_q;
	logic [DEPTH_BITS-1:0] fwd_depth_q;
	logic                  fwd_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_color_vld_q <= 1'b0;
			fwd_depth_vld_q <= 1'b0;
		end else if (sw.busy) begin
			fwd_color_vld_q <= 1'b0;
			fwd_depth_vld_q <= 1'b0;
		end else if (s2_move && (s2_color_wr || s2_depth_wr)) begin
			fwd_color_vld_q <= s2_color_wr;
			fwd_depth_vld_q <= s2_depth_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move && (s2_color_wr || s2_depth_wr)) begin
			fwd_addr_q  <= pix_s2.addr;
			fwd_color_q <= pix_s2.color;
			fwd_depth_q <= pix_s2.depth;
		end
	end

	// Depth test and result for the word in the second stage.
	logic [RGB_W-1:0]      cur_color;
	logic [DEPTH_BITS-1:0] cur_depth;
	logic                  pass;
	logic [STATUS_W-1:0]   status_d;
	logic [RGB_W-1:0]      rgb_d;

	always_comb begin
		fwd_hit   = (fwd_addr_q == pix_s2.addr);
		cur_color = (fwd_color_vld_q && fwd_hit) ? fwd_color_q : color_rd;
		cur_depth = (fwd_depth_vld_q && fwd_hit) ? fwd_depth_q : depth_rd;
		pass      = $signed(pix_s2.depth) >= $signed(cur_depth);

		s2_color_wr = !pix_s2.oor && (pix_s2.is_write || (pix_s2.is_test && pass));
		s2_depth_wr = !pix_s2.oor && pix_s2.is_test && pass;

		priority if (pix_s2.oor) begin
			status_d = ST_RANGE;
		end else if (pix_s2.is_test && !pass) begin
			status_d = ST_REJECT;
		end else begin
			status_d = ST_DONE;
		end

		rgb_d = (pix_s2.is_read && !pix_s2.oor) ? cur_color : '0;
	end

	// Clear sequencer. A clear command starts its pass as its result leaves
	// the second stage; a configuration write clears both stores.
	clr_req_t clr_req;

	always_comb begin
		clr_req.color = cfg_wr || (s2_move && pix_s2.clr_color);
		clr_req.depth = cfg_wr || (s2_move && pix_s2.clr_depth);
	end

	dtps_sweep u_sweep (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (clr_req),
		.sw     (sw)
	);

	// Output register.
	logic [STATUS_W-1:0] status_q;
	logic [RGB_W-1:0]    rgb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s2_open) begin
			out_vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			status_q <= status_d;
			rgb_q    <= rgb_d;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = {rgb_q[CHAN_W-1:0], rgb_q[2*CHAN_W-1:CHAN_W],
		rgb_q[RGB_W-1:2*CHAN_W]};

endmodule

@@ bench/tb_depth_tested_pixel_store_core.sv @@
`timescale 1ns / 100ps

module tb_depth_tested_pixel_store_core;
	import dtps_pkg::*;

	// Command codes that the block does not define; they must pass through as no-ops.
	localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;

	// Full intensity of a colour channel in Q3.12.
	localparam logic [CHAN_IN_W-1:0] CHAN_FULL = CHAN_IN_W'(1 << COLOR_FRAC_BITS);

	// One expected result word.
	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [CHAN_W-1:0]   red;
		logic [CHAN_W-1:0]   green;
		logic [CHAN_W-1:0]   blue;
	} pixel_result_t;

	// Shadow copy of the frame and depth stores. Every accepted command word updates
	// the shadow and queues the result word that the block must return for it.
	class pixel_store_scoreboard;
		bit [RGB_W-1:0]      color_mem [int];
		bit [DEPTH_BITS-1:0] depth_mem [int];
		int unsigned         frame_w;
		int unsigned         frame_h;
		pixel_result_t       result_q [$];
		int unsigned         fail_count;

		function new();
			frame_w = MAX_WIDTH;
			frame_h = MAX_HEIGHT;
			fail_count = 0;
		endfunction

		// A register write resizes the frame and wipes both stores.
		function void resize(logic idx, bit [DIM_W-1:0] value);
			int unsigned dim;
			int unsigned limit;
			limit = (idx == REG_WIDTH) ? MAX_WIDTH : MAX_HEIGHT;
			dim = (value == 0) ? 1 : value;
			if (dim > limit)
				dim = limit;
			if (idx == REG_WIDTH)
				frame_w = dim;
			else
				frame_h = dim;
			color_mem.delete();
			depth_mem.delete();
		endfunction

		// Clamp a signed Q3.12 channel to 0..1 and scale it to a byte, truncating.
		function bit [CHAN_W-1:0] chan_byte(bit [CHAN_IN_W-1:0] v);
			bit [31:0] scaled;
			if (v[CHAN_IN_W-1])
				return '0;
			if (v >= CHAN_FULL)
				return 8'hFF;
			scaled = (v * 255) >> COLOR_FRAC_BITS;
			return scaled[CHAN_W-1:0];
		endfunction

		function void note_command(bit [FUNC_W-1:0] func, bit [POS_W-1:0] x,
			bit [POS_W-1:0] y, bit [DEPTH_BITS-1:0] depth, bit [CHAN_IN_W-1:0] r,
			bit [CHAN_IN_W-1:0] g, bit [CHAN_IN_W-1:0] b);
			pixel_result_t      res;
			int                 addr;
			bit [RGB_W-1:0]     rgb;
			bit [DEPTH_BITS-1:0] old_depth;
			res.status = ST_DONE;
			res.red = '0;
			res.green = '0;
			res.blue = '0;
			case (func)
				FUNC_WRITE, FUNC_TEST, FUNC_READ: begin
					if (x >= frame_w || y >= frame_h) begin
						res.status = ST_RANGE;
					end else begin
						addr = y * frame_w + x;
						if (func == FUNC_READ) begin
							rgb = color_mem.exists(addr) ? color_mem[addr] : '0;
							res.red = rgb[23:16];
							res.green = rgb[15:8];
							res.blue = rgb[7:0];
						end else begin
							old_depth = depth_mem.exists(addr) ? depth_mem[addr] : '0;
							if (func == FUNC_TEST && $signed(depth) < $signed(old_depth)) begin
								res.status = ST_REJECT;
							end else begin
								color_mem[addr] = {chan_byte(r), chan_byte(g), chan_byte(b)};
								if (func == FUNC_TEST)
									depth_mem[addr] = depth;
							end
						end
					end
				end
				FUNC_CLR_COLOR: color_mem.delete();
				FUNC_CLR_DEPTH: depth_mem.delete();
				default: ;
			endcase
			result_q.push_back(res);
		endfunction

		function void check_result(bit [STATUS_W-1:0] status, bit [RGB_W-1:0] data);
			pixel_result_t want;
			if (result_q.size() == 0) begin
				$error("result word with no command waiting: status %0d data %h", status, data);
				fail_count++;
				return;
			end
			want = result_q.pop_front();
			if (status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, status);
				fail_count++;
			end
			if (data[7:0] !== want.red) begin
				$error("red_out: expected %0d, got %0d", want.red, data[7:0]);
				fail_count++;
			end
			if (data[15:8] !== want.green) begin
				$error("green_out: expected %0d, got %0d", want.green, data[15:8]);
				fail_count++;
			end
			if (data[23:16] !== want.blue) begin
				$error("blue_out: expected %0d, got %0d", want.blue, data[23:16]);
				fail_count++;
			end
		endfunction

		function int pending();
			return result_q.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [95:0]          s_axis_tdata;
	logic [FUNC_W-1:0]    s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [RGB_W-1:0]     m_axis_tdata;
	logic [STATUS_W-1:0]  m_axis_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic                 cfg_index;
	logic [DIM_W-1:0]     cfg_data;

	pixel_store_scoreboard sb = new();

	// Random clear commands each start a full sweep of the stores, so only a few
	// are allowed in the whole run to keep it short.
	int unsigned clears_left = 3;

	depth_tested_pixel_store_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog. The slowest legal run has at most twelve full store sweeps, plus the
	// command words with their stalls, which stays under 10 ms.
	initial begin
		#40_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Every result word accepted at a rising edge is checked against the oldest
	// outstanding expectation.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tuser, m_axis_tdata);
	end

	// Result side back-pressure. Stretches of steady readiness and stretches of random
	// stalls come in random order; the stalls are mostly short with the odd long one.
	initial begin
		int unsigned stretch;
		int unsigned hold;
		int unsigned r;
		bit          calm;
		m_axis_tready = 1'b0;
		hold = 0;
		forever begin
			stretch = $urandom_range(200, 20);
			calm = ($urandom_range(3) == 0);
			repeat (stretch) begin
				@(negedge clk);
				if (calm) begin
					m_axis_tready = 1'b1;
				end else if (hold > 0) begin
					m_axis_tready = 1'b0;
					hold--;
				end else begin
					r = $urandom_range(99);
					if (r < 70) begin
						m_axis_tready = 1'b1;
					end else begin
						m_axis_tready = 1'b0;
						hold = (r < 95) ? $urandom_range(3, 1) : $urandom_range(40, 10);
					end
				end
			end
		end
	end

	// Present one command word and hold it until the block takes it. Entered and
	// left at a falling edge; the valid stays high so the next word can follow
	// without a bubble.
	task automatic send_cmd(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] x,
		input logic [POS_W-1:0] y, input logic [DEPTH_BITS-1:0] depth,
		input logic [CHAN_IN_W-1:0] r, input logic [CHAN_IN_W-1:0] g,
		input logic [CHAN_IN_W-1:0] b);
		s_axis_tuser = func;
		s_axis_tdata = {b, g, r, depth, y, x};
		s_axis_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_command(func, x, y, depth, r, g, b);
		@(negedge clk);
	endtask

	// Sender gap: usually none, sometimes a few cycles, rarely a long pause.
	task automatic sender_gap(input bit burst);
		int unsigned r;
		int unsigned n;
		r = $urandom_range(99);
		if (burst || r < 60)
			n = 0;
		else if (r < 90)
			n = $urandom_range(3, 1);
		else if (r < 98)
			n = $urandom_range(10, 4);
		else
			n = $urandom_range(60, 20);
		if (n > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// Let every outstanding result come back, then let the pipeline settle.
	task automatic drain();
		s_axis_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Register writes happen only with the pipeline drained. Each one starts a sweep of
	// both stores, which the block signals by holding its ready low.
	task automatic write_reg(input logic idx, input logic [DIM_W-1:0] value);
		drain();
		cfg_index = idx;
		cfg_data = value;
		cfg_valid = 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.resize(idx, value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Any coordinate and any channel value, for fields that should not matter.
	function automatic logic [POS_W-1:0] any_pos();
		return POS_W'($urandom);
	endfunction

	function automatic logic [CHAN_IN_W-1:0] any_chan();
		return CHAN_IN_W'($urandom);
	endfunction

	// Coordinates mostly fall in a small corner of the frame so that writes, depth
	// tests and reads keep hitting the same pixels; the rest probe the last column or
	// row, coordinates past the edge, and the whole range.
	function automatic logic [POS_W-1:0] pick_coord(input int unsigned lim);
		int unsigned r;
		int unsigned window;
		r = $urandom_range(99);
		window = (lim < 6) ? lim : 6;
		if (r < 70)
			return POS_W'($urandom_range(window - 1));
		if (r < 80)
			return POS_W'(lim - 1);
		if (r < 88 && lim < 256)
			return POS_W'($urandom_range(255, lim));
		return POS_W'($urandom_range(255));
	endfunction

	// Depths cluster around zero so that ties and near misses are common.
	function automatic logic [DEPTH_BITS-1:0] pick_depth();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55)
			return $urandom_range(8) - 4;
		if (r < 65)
			return ($urandom_range(1) == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
		return $urandom;
	endfunction

	function automatic logic [CHAN_IN_W-1:0] pick_chan();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 25)
			return CHAN_IN_W'($urandom);
		if (r < 70)
			return CHAN_IN_W'($urandom_range(CHAN_FULL));
		if (r < 78)
			return CHAN_FULL;
		if (r < 86)
			return CHAN_FULL - 1'b1;
		return CHAN_IN_W'(16'h8000 | $urandom);
	endfunction

	// Random command words for the current frame size. A pause in the middle of
	// the first run holds the sender until the pipeline is empty.
	task automatic run_random(input int unsigned count, input bit pause_mid);
		int unsigned          i;
		int unsigned          r;
		int unsigned          burst_left;
		logic [FUNC_W-1:0]    func;
		burst_left = 0;
		for (i = 0; i < count; i++) begin
			r = $urandom_range(999);
			if (r < 4 && clears_left > 0) begin
				func = ($urandom_range(1) == 0) ? FUNC_CLR_COLOR : FUNC_CLR_DEPTH;
				clears_left--;
			end else if (r < 320) begin
				func = FUNC_TEST;
			end else if (r < 560) begin
				func = FUNC_WRITE;
			end else if (r < 950) begin
				func = FUNC_READ;
			end else begin
				func = FUNC_W'($urandom_range(FUNC_SPARE_LAST, FUNC_SPARE_FIRST));
			end
			send_cmd(func, pick_coord(sb.frame_w), pick_coord(sb.frame_h), pick_depth(),
				pick_chan(), pick_chan(), pick_chan());
			if (burst_left > 0)
				burst_left--;
			else if ($urandom_range(15) == 0)
				burst_left = $urandom_range(60, 20);
			sender_gap(burst_left > 0);
			if (pause_mid && i == count / 2) begin
				s_axis_tvalid = 1'b0;
				while (sb.pending() != 0)
					@(negedge clk);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = FUNC_WRITE;
		cfg_valid = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Directed words at the reset size of 256 by 256. The block is still sweeping
		// its stores after reset, so the first word waits on its ready.
		send_cmd(FUNC_READ, 8'd0, 8'd0, '0, '0, '0, '0);
		// Full, one below full and zero intensity.
		send_cmd(FUNC_WRITE, 8'd0, 8'd0, 32'd5, CHAN_FULL, CHAN_FULL - 1'b1, 16'd0);
		send_cmd(FUNC_READ, 8'd0, 8'd0, '0, '0, '0, '0);
		// Far corner; the largest positive channel saturates, negatives give zero.
		send_cmd(FUNC_WRITE, 8'd255, 8'd255, '1, 16'h7FFF, 16'h8000, 16'hFFFF);
		send_cmd(FUNC_READ, 8'd255, 8'd255, '0, '0, '0, '0);
		// Depth test: the largest depth wins, the smallest loses, a tie still wins.
		send_cmd(FUNC_TEST, 8'd10, 8'd10, 32'h7FFF_FFFF, 16'd2048, 16'd1, CHAN_FULL);
		send_cmd(FUNC_TEST, 8'd10, 8'd10, 32'h8000_0000, CHAN_FULL, CHAN_FULL, CHAN_FULL);
		send_cmd(FUNC_TEST, 8'd10, 8'd10, 32'h7FFF_FFFF, 16'd100, 16'd200, 16'd300);
		send_cmd(FUNC_READ, 8'd10, 8'd10, '0, '0, '0, '0);
		// Negative depth against the cleared value of zero loses, zero itself wins.
		send_cmd(FUNC_TEST, 8'd11, 8'd10, 32'hFFFF_FFFF, CHAN_FULL, '0, '0);
		send_cmd(FUNC_TEST, 8'd11, 8'd10, 32'd0, CHAN_FULL, '0, '0);
		// Undefined command codes change nothing.
		send_cmd(FUNC_SPARE_FIRST, 8'd11, 8'd10, $urandom, any_chan(), any_chan(),
			any_chan());
		send_cmd(FUNC_SPARE_FIRST + 3'd1, any_pos(), any_pos(), $urandom, any_chan(),
			any_chan(), any_chan());
		send_cmd(FUNC_SPARE_LAST, 8'd11, 8'd10, $urandom, any_chan(), any_chan(),
			any_chan());
		send_cmd(FUNC_READ, 8'd11, 8'd10, '0, '0, '0, '0);
		// Colour clear keeps the stored depth, so a lower depth is still rejected.
		send_cmd(FUNC_CLR_COLOR, any_pos(), any_pos(), $urandom, any_chan(), any_chan(),
			any_chan());
		send_cmd(FUNC_READ, 8'd10, 8'd10, '0, '0, '0, '0);
		send_cmd(FUNC_TEST, 8'd10, 8'd10, 32'h7FFF_FFFE, CHAN_FULL, CHAN_FULL, CHAN_FULL);
		// Depth clear brings the depth back to zero.
		send_cmd(FUNC_CLR_DEPTH, any_pos(), any_pos(), $urandom, any_chan(), any_chan(),
			any_chan());
		send_cmd(FUNC_TEST, 8'd10, 8'd10, 32'hFFFF_FFFB, CHAN_FULL, CHAN_FULL, CHAN_FULL);
		send_cmd(FUNC_TEST, 8'd10, 8'd10, 32'd0, 16'd1234, 16'd2345, 16'd3456);
		send_cmd(FUNC_READ, 8'd10, 8'd10, '0, '0, '0, '0);
		run_random(300, 1'b1);

		// A width above the maximum acts as the maximum; a short frame of five rows.
		write_reg(REG_WIDTH, 9'd300);
		write_reg(REG_HEIGHT, 9'd5);
		send_cmd(FUNC_WRITE, 8'd3, 8'd5, '0, CHAN_FULL, CHAN_FULL, CHAN_FULL);
		send_cmd(FUNC_READ, 8'd255, 8'd255, '0, '0, '0, '0);
		send_cmd(FUNC_READ, 8'd255, 8'd4, '0, '0, '0, '0);
		run_random(150, 1'b0);

		// A width of zero acts as one; the all-ones height acts as the maximum.
		write_reg(REG_WIDTH, 9'd0);
		write_reg(REG_HEIGHT, 9'h1FF);
		send_cmd(FUNC_TEST, 8'd1, 8'd0, 32'd7, CHAN_FULL, CHAN_FULL, CHAN_FULL);
		send_cmd(FUNC_TEST, 8'd0, 8'd255, 32'd7, 16'd512, 16'd1024, 16'd3000);
		send_cmd(FUNC_READ, 8'd0, 8'd255, '0, '0, '0, '0);
		run_random(100, 1'b0);

		// An odd row stride and a single row.
		write_reg(REG_WIDTH, 9'd37);
		write_reg(REG_HEIGHT, 9'd1);
		run_random(200, 1'b0);

		// Wait for the last results, then give the pipeline time to show any extra.
		s_axis_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d results never arrived", sb.pending());
			sb.fail_count++;
		end
		if (sb.fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/dtps_pkg.sv
rtl/core/dtps_ram.sv
rtl/core/dtps_front.sv
rtl/core/dtps_sweep.sv
rtl/core/depth_tested_pixel_store_core.sv
bench/tb_depth_tested_pixel_store_core.sv
